// ----- design/chip8_interpreter_core_unit_assert.svh -----
// Assertion macros for the CHIP-8 interpreter core.
// Included by modules that check their own logic; needs clk and rst in scope.
`ifndef CHIP8_INTERPRETER_CORE_UNIT_ASSERT_SVH
`define CHIP8_INTERPRETER_CORE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define C8IC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c8ic assertion failed");
`define C8IC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c8ic assertion failed");
`else
`define C8IC_ASSERT_SAME(label, ante, cons)
`define C8IC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/c8ic_pkg.sv -----
// Shared types, codes and constants of the CHIP-8 interpreter core.
// No dependencies; used by the controller, datapath and top level.
package c8ic_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int SCREEN_WIDTH = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FONT_BYTES = 80;
  localparam logic [11:0] START_PC = 12'h200;
  localparam logic [11:0] ADDR_LAST = 12'hFFF;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_ROW   = 2'd3
  } req_e_t;

  // Instruction classes by top nibble.
  localparam logic [3:0] OPC_SYS   = 4'h0;
  localparam logic [3:0] OPC_JUMP  = 4'h1;
  localparam logic [3:0] OPC_CALL  = 4'h2;
  localparam logic [3:0] OPC_SEQI  = 4'h3;
  localparam logic [3:0] OPC_SNEI  = 4'h4;
  localparam logic [3:0] OPC_SEQR  = 4'h5;
  localparam logic [3:0] OPC_LDI   = 4'h6;
  localparam logic [3:0] OPC_ADDI  = 4'h7;
  localparam logic [3:0] OPC_ALU   = 4'h8;
  localparam logic [3:0] OPC_SNER  = 4'h9;
  localparam logic [3:0] OPC_LIDX  = 4'hA;
  localparam logic [3:0] OPC_JOFS  = 4'hB;
  localparam logic [3:0] OPC_RAND  = 4'hC;
  localparam logic [3:0] OPC_DRAW  = 4'hD;
  localparam logic [3:0] OPC_KEY   = 4'hE;
  localparam logic [3:0] OPC_MISC  = 4'hF;

  // Low-nibble codes of the register ALU group.
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Low-byte codes.
  localparam logic [7:0] NN_CLS   = 8'hE0;
  localparam logic [7:0] NN_RET   = 8'hEE;
  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_WKEY  = 8'h0A;
  localparam logic [7:0] NN_GDLY  = 8'h07;
  localparam logic [7:0] NN_SDLY  = 8'h15;
  localparam logic [7:0] NN_SSND  = 8'h18;
  localparam logic [7:0] NN_AIDX  = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  // Controller states, one-hot.
  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_START = 18'h00004,
    S_FET1  = 18'h00008,
    S_FET2  = 18'h00010,
    S_RDY   = 18'h00020,
    S_CAPY  = 18'h00040,
    S_EXEC  = 18'h00080,
    S_WRF   = 18'h00100,
    S_STRD  = 18'h00200,
    S_STWR  = 18'h00400,
    S_LDRD  = 18'h00800,
    S_LDWR  = 18'h01000,
    S_BCD   = 18'h02000,
    S_DRRD  = 18'h04000,
    S_DRXOR = 18'h08000,
    S_DRF   = 18'h10000,
    S_RESP  = 18'h20000
  } state_t;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    MOP_NONE, MOP_CLR, MOP_LATCH, MOP_START, MOP_FET1, MOP_FET2, MOP_RDY,
    MOP_CAPY, MOP_EXEC, MOP_WRF, MOP_STRD, MOP_STWR, MOP_LDRD, MOP_LDWR,
    MOP_BCD, MOP_DRRD, MOP_DRXOR, MOP_DRF, MOP_RESP
  } mop_t;

  typedef struct packed {
    mop_t       mop;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    req_e_t      req;
    logic [15:0] op;
    logic        clr_last;
    logic        draw_break;
  } status_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Power-up contents of one memory byte.
  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [7:0] b;
    b = 8'd0;
    if (a < 12'(FONT_BYTES)) begin
      b = FONT[a[6:0]];
    end
    return b;
  endfunction

endpackage

// ----- design/c8ic_if.sv -----
// Handshake channel interfaces of the CHIP-8 interpreter core.
// Depends on nothing; payload widths follow the request and result items.
interface c8ic_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] address;
  logic [7:0]  write_byte;
  logic [4:0]  row_index;
  logic [15:0] key_state;
  logic [7:0]  random_byte;
  modport source (output valid, req_type, address, write_byte, row_index, key_state,
                  random_byte, input ready);
  modport sink (input valid, req_type, address, write_byte, row_index, key_state,
                random_byte, output ready);
endinterface

interface c8ic_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] executed_opcode;
  logic [63:0] display_row;
  logic        display_changed;
  logic        sound_on;
  logic        waiting_key;
  modport source (output valid, program_counter, executed_opcode, display_row,
                  display_changed, sound_on, waiting_key, input ready);
  modport sink (input valid, program_counter, executed_opcode, display_row,
                display_changed, sound_on, waiting_key, output ready);
endinterface

// ----- design/c8ic_ctrl.sv -----
// Controller state machine of the CHIP-8 interpreter core.
// Depends on c8ic_pkg and the assertion macro header; drives the datapath by command.
`include "chip8_interpreter_core_unit_assert.svh"

module c8ic_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  c8ic_pkg::status_t  st,
  output c8ic_pkg::cmd_t     cmd
);

  c8ic_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid_next;
  logic [3:0] nib, x, n;
  logic [7:0] nn;

  assign nib = st.op[15:12];
  assign x   = st.op[11:8];
  assign n   = st.op[3:0];
  assign nn  = st.op[7:0];
  assign in_ready = (state == c8ic_pkg::S_IDLE);

  // Next state and command for the datapath.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd.mop = c8ic_pkg::MOP_NONE;
    cmd.cnt = cnt;
    case (state)
      c8ic_pkg::S_CLR: begin
        cmd.mop = c8ic_pkg::MOP_CLR;
        if (st.clr_last) state_next = c8ic_pkg::S_IDLE;
      end
      c8ic_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.mop = c8ic_pkg::MOP_LATCH;
          state_next = c8ic_pkg::S_START;
        end
      end
      c8ic_pkg::S_START: begin
        cmd.mop = c8ic_pkg::MOP_START;
        state_next = (st.req == c8ic_pkg::REQ_EXEC) ? c8ic_pkg::S_FET1 : c8ic_pkg::S_RESP;
      end
      c8ic_pkg::S_FET1: begin
        cmd.mop = c8ic_pkg::MOP_FET1;
        state_next = c8ic_pkg::S_FET2;
      end
      c8ic_pkg::S_FET2: begin
        cmd.mop = c8ic_pkg::MOP_FET2;
        state_next = c8ic_pkg::S_RDY;
      end
      c8ic_pkg::S_RDY: begin
        cmd.mop = c8ic_pkg::MOP_RDY;
        state_next = c8ic_pkg::S_CAPY;
      end
      c8ic_pkg::S_CAPY: begin
        cmd.mop = c8ic_pkg::MOP_CAPY;
        state_next = c8ic_pkg::S_EXEC;
      end
      c8ic_pkg::S_EXEC: begin
        cmd.mop = c8ic_pkg::MOP_EXEC;
        cnt_next = 4'd0;
        state_next = c8ic_pkg::S_RESP;
        if (nib == c8ic_pkg::OPC_DRAW) begin
          state_next = c8ic_pkg::S_DRRD;
        end else if (nib == c8ic_pkg::OPC_MISC) begin
          if (nn == c8ic_pkg::NN_STORE) state_next = c8ic_pkg::S_STRD;
          else if (nn == c8ic_pkg::NN_LOAD) state_next = c8ic_pkg::S_LDRD;
          else if (nn == c8ic_pkg::NN_BCD) state_next = c8ic_pkg::S_BCD;
        end else if (nib == c8ic_pkg::OPC_ALU) begin
          if (n inside {c8ic_pkg::ALU_OR, c8ic_pkg::ALU_AND, c8ic_pkg::ALU_XOR,
                        c8ic_pkg::ALU_ADD, c8ic_pkg::ALU_SUB, c8ic_pkg::ALU_SHR,
                        c8ic_pkg::ALU_SBN, c8ic_pkg::ALU_SHL}) begin
            state_next = c8ic_pkg::S_WRF;
          end
        end
      end
      c8ic_pkg::S_WRF: begin
        cmd.mop = c8ic_pkg::MOP_WRF;
        state_next = c8ic_pkg::S_RESP;
      end
      c8ic_pkg::S_STRD: begin
        cmd.mop = c8ic_pkg::MOP_STRD;
        state_next = c8ic_pkg::S_STWR;
      end
      c8ic_pkg::S_STWR: begin
        cmd.mop = c8ic_pkg::MOP_STWR;
        cnt_next = cnt + 4'd1;
        state_next = (cnt == x) ? c8ic_pkg::S_RESP : c8ic_pkg::S_STRD;
      end
      c8ic_pkg::S_LDRD: begin
        cmd.mop = c8ic_pkg::MOP_LDRD;
        state_next = c8ic_pkg::S_LDWR;
      end
      c8ic_pkg::S_LDWR: begin
        cmd.mop = c8ic_pkg::MOP_LDWR;
        cnt_next = cnt + 4'd1;
        state_next = (cnt == x) ? c8ic_pkg::S_RESP : c8ic_pkg::S_LDRD;
      end
      c8ic_pkg::S_BCD: begin
        cmd.mop = c8ic_pkg::MOP_BCD;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd2) state_next = c8ic_pkg::S_RESP;
      end
      c8ic_pkg::S_DRRD: begin
        if (cnt == n || st.draw_break) begin
          state_next = c8ic_pkg::S_DRF;
        end else begin
          cmd.mop = c8ic_pkg::MOP_DRRD;
          state_next = c8ic_pkg::S_DRXOR;
        end
      end
      c8ic_pkg::S_DRXOR: begin
        cmd.mop = c8ic_pkg::MOP_DRXOR;
        cnt_next = cnt + 4'd1;
        state_next = c8ic_pkg::S_DRRD;
      end
      c8ic_pkg::S_DRF: begin
        cmd.mop = c8ic_pkg::MOP_DRF;
        state_next = c8ic_pkg::S_RESP;
      end
      c8ic_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.mop = c8ic_pkg::MOP_RESP;
          out_valid_next = 1'b1;
          state_next = c8ic_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = c8ic_pkg::S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8ic_pkg::S_CLR;
      cnt <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `C8IC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == c8ic_pkg::S_START)
  `C8IC_ASSERT_SAME(a_clear_blocks_input, state == c8ic_pkg::S_CLR, !in_ready)
  `C8IC_ASSERT_NEXT(a_resp_gives_valid, state == c8ic_pkg::S_RESP && (!out_valid || out_ready), out_valid)
  `C8IC_ASSERT_SAME(a_bcd_count, state == c8ic_pkg::S_BCD, cnt <= 4'd2)

endmodule

// ----- design/c8ic_dp.sv -----
// Datapath of the CHIP-8 interpreter core: memory, registers, stack, timers, display.
// Depends on c8ic_pkg; every action is selected by the controller's command.
module c8ic_dp #(
  parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  c8ic_pkg::cmd_t     cmd,
  output c8ic_pkg::status_t  st,
  input  logic [1:0]         req_type,
  input  logic [11:0]        address,
  input  logic [7:0]         write_byte,
  input  logic [4:0]         row_index,
  input  logic [15:0]        key_state,
  input  logic [7:0]         random_byte,
  output logic [11:0]        program_counter,
  output logic [15:0]        executed_opcode,
  output logic [63:0]        display_row,
  output logic               display_changed,
  output logic               sound_on,
  output logic               waiting_key
);

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  // Storage.
  logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
  logic [7:0]  rf [16];
  logic [15:0] rf_vld;
  logic [63:0] frame [c8ic_pkg::SCREEN_HEIGHT];
  logic [31:0] fr_vld;
  logic [11:0] stack [STACK_DEPTH];

  // Architectural state.
  logic [11:0] pc, pc_next;
  logic [15:0] idx, idx_next;
  logic [SP_W-1:0] sp, sp_next;
  logic [7:0]  dly, dly_next, snd, snd_next;
  logic        wseen, wseen_next;
  logic [3:0]  wnum, wnum_next;
  logic [11:0] clr_addr;

  // Working registers.
  c8ic_pkg::req_e_t req_l;
  logic [11:0] addr_l;
  logic [7:0]  wbyte_l, rnd_l;
  logic [4:0]  row_l;
  logic [15:0] keys_l;
  logic [15:0] op;
  logic [7:0]  vx, vy, mem_q, rf_raw;
  logic        rf_qv, fr_qv;
  logic [63:0] fr_raw;
  logic [4:0]  dr_row;
  logic [4:0]  bcd_t;
  logic [1:0]  bcd_h;
  logic        flag, flag_next, coll, chg, chg_next, snd_o, snd_o_next, wt, wt_next;

  // Port signals.
  logic        mem_we;
  logic [11:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  logic        rf_we;
  logic [3:0]  rf_wa, rf_ra;
  logic [7:0]  rf_wd, rf_q;
  logic        fr_we, fr_clr;
  logic [4:0]  fr_ra;
  logic [63:0] fr_old, dr_mask;
  logic        stk_we;

  logic [3:0]  nib, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  rsum;
  logic        dr_break;
  logic [3:0]  low_key;
  logic        any_key;
  logic [8:0]  add9;
  logic [15:0] mul_t;
  logic [13:0] mul_h;
  logic [7:0]  bcd_one;
  logic [3:0]  bcd_ten;
  logic [SP_W-1:0] sp_dec;

  assign nib = op[15:12];
  assign x   = op[11:8];
  assign y   = op[7:4];
  assign n   = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[11:0];
  assign rf_q   = rf_qv ? rf_raw : 8'd0;
  assign fr_old = fr_qv ? fr_raw : 64'd0;
  assign add9 = {1'b0, vx} + {1'b0, vy};
  assign mul_t = 16'(vx) * 16'd205;
  assign mul_h = 14'(vx) * 14'd41;
  assign bcd_one = vx - {bcd_t, 3'b000} - {2'b00, bcd_t, 1'b0};
  assign bcd_ten = 4'(bcd_t - {bcd_h, 3'b000} - {2'b00, bcd_h, 1'b0});
  assign sp_dec = (sp == '0) ? SP_LAST : sp - 1'b1;

  // Sprite row placement: a row start offscreen wraps, one onscreen clips.
  assign rsum = vy + {4'd0, cmd.cnt};
  assign dr_break = (rsum >= 8'd32) && (vy < 8'd32);

  // Pixel mask of one sprite byte.
  always_comb begin
    logic [7:0] col;
    dr_mask = '0;
    for (int j = 0; j < 8; j++) begin
      col = vx + 8'(j);
      if (mem_q[7 - j] && (col < 8'd64 || vx >= 8'd64)) begin
        dr_mask[6'd63 - col[5:0]] = 1'b1;
      end
    end
  end

  // Lowest held key.
  always_comb begin
    low_key = 4'd0;
    any_key = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_l[k]) begin
        low_key = 4'(k);
        any_key = 1'b1;
      end
    end
  end

  // Per-command port control and next state.
  always_comb begin
    logic [3:0] kn;
    logic       ks;
    kn = wnum;
    ks = wseen;
    pc_next = pc;
    idx_next = idx;
    sp_next = sp;
    dly_next = dly;
    snd_next = snd;
    wseen_next = wseen;
    wnum_next = wnum;
    flag_next = flag;
    chg_next = chg;
    snd_o_next = snd_o;
    wt_next = wt;
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = c8ic_pkg::font_byte(clr_addr);
    mem_ra = pc;
    rf_we = 1'b0;
    rf_wa = x;
    rf_wd = 8'd0;
    rf_ra = x;
    fr_we = 1'b0;
    fr_clr = 1'b0;
    fr_ra = row_l;
    stk_we = 1'b0;
    case (cmd.mop)
      c8ic_pkg::MOP_CLR: begin
        mem_we = 1'b1;
      end
      c8ic_pkg::MOP_LATCH: begin
        chg_next = 1'b0;
        snd_o_next = 1'b0;
        wt_next = 1'b0;
      end
      c8ic_pkg::MOP_START: begin
        if (req_l == c8ic_pkg::REQ_WRITE) begin
          mem_we = 1'b1;
          mem_wa = addr_l;
          mem_wd = wbyte_l;
        end
        if (req_l == c8ic_pkg::REQ_TICK) begin
          if (dly != 8'd0) dly_next = dly - 8'd1;
          if (snd != 8'd0) begin
            snd_next = snd - 8'd1;
            snd_o_next = 1'b1;
          end
        end
      end
      c8ic_pkg::MOP_FET1: begin
        mem_ra = pc + 12'd1;
      end
      c8ic_pkg::MOP_FET2: begin
        pc_next = pc + 12'd2;
      end
      c8ic_pkg::MOP_RDY: begin
        rf_ra = (nib == c8ic_pkg::OPC_JOFS) ? 4'd0 : y;
      end
      c8ic_pkg::MOP_EXEC: begin
        case (nib)
          c8ic_pkg::OPC_SYS: begin
            if (nn == c8ic_pkg::NN_CLS) begin
              fr_clr = 1'b1;
              chg_next = 1'b1;
            end else if (nn == c8ic_pkg::NN_RET) begin
              sp_next = sp_dec;
              pc_next = stack[sp_dec];
            end
          end
          c8ic_pkg::OPC_JUMP: pc_next = nnn;
          c8ic_pkg::OPC_CALL: begin
            stk_we = 1'b1;
            sp_next = (sp == SP_LAST) ? '0 : sp + 1'b1;
            pc_next = nnn;
          end
          c8ic_pkg::OPC_SEQI: if (vx == nn) pc_next = pc + 12'd2;
          c8ic_pkg::OPC_SNEI: if (vx != nn) pc_next = pc + 12'd2;
          c8ic_pkg::OPC_SEQR: if (vx == vy) pc_next = pc + 12'd2;
          c8ic_pkg::OPC_SNER: if (vx != vy) pc_next = pc + 12'd2;
          c8ic_pkg::OPC_LDI: begin
            rf_we = 1'b1;
            rf_wd = nn;
          end
          c8ic_pkg::OPC_ADDI: begin
            rf_we = 1'b1;
            rf_wd = vx + nn;
          end
          c8ic_pkg::OPC_ALU: begin
            rf_we = 1'b1;
            flag_next = 1'b0;
            case (n)
              c8ic_pkg::ALU_MOV: rf_wd = vy;
              c8ic_pkg::ALU_OR:  rf_wd = vx | vy;
              c8ic_pkg::ALU_AND: rf_wd = vx & vy;
              c8ic_pkg::ALU_XOR: rf_wd = vx ^ vy;
              c8ic_pkg::ALU_ADD: begin
                rf_wd = add9[7:0];
                flag_next = add9[8];
              end
              c8ic_pkg::ALU_SUB: begin
                rf_wd = vx - vy;
                flag_next = (vy <= vx);
              end
              c8ic_pkg::ALU_SHR: begin
                rf_wd = {1'b0, vy[7:1]};
                flag_next = vy[0];
              end
              c8ic_pkg::ALU_SBN: begin
                rf_wd = vy - vx;
                flag_next = (vx <= vy);
              end
              c8ic_pkg::ALU_SHL: begin
                rf_wd = {vy[6:0], 1'b0};
                flag_next = vy[7];
              end
              default: rf_we = 1'b0;
            endcase
          end
          c8ic_pkg::OPC_LIDX: idx_next = {4'd0, nnn};
          c8ic_pkg::OPC_JOFS: pc_next = nnn + {4'd0, vy};
          c8ic_pkg::OPC_RAND: begin
            rf_we = 1'b1;
            rf_wd = rnd_l & nn;
          end
          c8ic_pkg::OPC_DRAW: begin
            // The sprite row count starts at zero; nothing else to do here.
          end
          c8ic_pkg::OPC_KEY: begin
            if (nn == c8ic_pkg::NN_SKP) begin
              if (vx[7:4] == 4'd0 && keys_l[vx[3:0]]) pc_next = pc + 12'd2;
            end else if (nn == c8ic_pkg::NN_SKNP) begin
              if (!(vx[7:4] == 4'd0 && keys_l[vx[3:0]])) pc_next = pc + 12'd2;
            end
          end
          default: begin
            case (nn)
              c8ic_pkg::NN_WKEY: begin
                if (!wseen && any_key) begin
                  ks = 1'b1;
                  kn = low_key;
                end
                if (!ks || keys_l[kn]) begin
                  pc_next = pc - 12'd2;
                  wt_next = 1'b1;
                  wseen_next = ks;
                  wnum_next = kn;
                end else begin
                  rf_we = 1'b1;
                  rf_wd = {4'd0, kn};
                  wseen_next = 1'b0;
                  wnum_next = 4'd0;
                end
              end
              c8ic_pkg::NN_GDLY: begin
                rf_we = 1'b1;
                rf_wd = dly;
              end
              c8ic_pkg::NN_SDLY: dly_next = vx;
              c8ic_pkg::NN_SSND: snd_next = vx;
              c8ic_pkg::NN_AIDX: idx_next = idx + {8'd0, vx};
              c8ic_pkg::NN_FONT: idx_next = 16'(vx) * 16'd5;
              default: begin
              end
            endcase
          end
        endcase
      end
      c8ic_pkg::MOP_WRF: begin
        rf_we = 1'b1;
        rf_wa = 4'd15;
        rf_wd = {7'd0, flag};
      end
      c8ic_pkg::MOP_STRD: begin
        rf_ra = cmd.cnt;
      end
      c8ic_pkg::MOP_STWR: begin
        mem_we = 1'b1;
        mem_wa = idx[11:0];
        mem_wd = rf_q;
        idx_next = idx + 16'd1;
      end
      c8ic_pkg::MOP_LDRD: begin
        mem_ra = idx[11:0];
      end
      c8ic_pkg::MOP_LDWR: begin
        rf_we = 1'b1;
        rf_wa = cmd.cnt;
        rf_wd = mem_q;
        idx_next = idx + 16'd1;
      end
      c8ic_pkg::MOP_BCD: begin
        mem_we = 1'b1;
        if (cmd.cnt == 4'd0) begin
          mem_wa = idx[11:0] + 12'd2;
          mem_wd = bcd_one;
        end else if (cmd.cnt == 4'd1) begin
          mem_wa = idx[11:0] + 12'd1;
          mem_wd = {4'd0, bcd_ten};
        end else begin
          mem_wa = idx[11:0];
          mem_wd = {6'd0, bcd_h};
        end
      end
      c8ic_pkg::MOP_DRRD: begin
        mem_ra = idx[11:0] + {8'd0, cmd.cnt};
        fr_ra = rsum[4:0];
      end
      c8ic_pkg::MOP_DRXOR: begin
        fr_we = 1'b1;
        chg_next = 1'b1;
      end
      c8ic_pkg::MOP_DRF: begin
        rf_we = 1'b1;
        rf_wa = 4'd15;
        rf_wd = {7'd0, coll};
      end
      default: begin
      end
    endcase
  end

  // Main memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // Register file and display rows, with registered reads.
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rf_raw <= rf[rf_ra];
    rf_qv <= rf_vld[rf_ra];
    if (fr_we) frame[dr_row] <= fr_old ^ dr_mask;
    fr_raw <= frame[fr_ra];
    fr_qv <= fr_vld[fr_ra];
  end

  // Architectural state with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= c8ic_pkg::START_PC;
      idx <= 16'd0;
      sp <= '0;
      dly <= 8'd0;
      snd <= 8'd0;
      wseen <= 1'b0;
      wnum <= 4'd0;
      clr_addr <= 12'd0;
      rf_vld <= 16'd0;
      fr_vld <= 32'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= 12'd0;
    end else begin
      pc <= pc_next;
      idx <= idx_next;
      sp <= sp_next;
      dly <= dly_next;
      snd <= snd_next;
      wseen <= wseen_next;
      wnum <= wnum_next;
      if (cmd.mop == c8ic_pkg::MOP_CLR) clr_addr <= clr_addr + 12'd1;
      if (rf_we) rf_vld[rf_wa] <= 1'b1;
      if (fr_clr) fr_vld <= 32'd0;
      else if (fr_we) fr_vld[dr_row] <= 1'b1;
      if (stk_we) stack[sp] <= pc;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    flag <= flag_next;
    chg <= chg_next;
    snd_o <= snd_o_next;
    wt <= wt_next;
    case (cmd.mop)
      c8ic_pkg::MOP_LATCH: begin
        req_l <= c8ic_pkg::req_e_t'(req_type);
        addr_l <= address;
        wbyte_l <= write_byte;
        row_l <= row_index;
        keys_l <= key_state;
        rnd_l <= random_byte;
      end
      c8ic_pkg::MOP_FET1: op[15:8] <= mem_q;
      c8ic_pkg::MOP_FET2: op[7:0] <= mem_q;
      c8ic_pkg::MOP_RDY:  vx <= rf_q;
      c8ic_pkg::MOP_CAPY: vy <= rf_q;
      c8ic_pkg::MOP_EXEC: begin
        bcd_t <= mul_t[15:11];
        bcd_h <= mul_h[13:12];
        coll <= 1'b0;
        // Drawing clears VF before the coordinates are taken.
        if (nib == c8ic_pkg::OPC_DRAW && x == 4'd15) vx <= 8'd0;
        if (nib == c8ic_pkg::OPC_DRAW && y == 4'd15) vy <= 8'd0;
      end
      c8ic_pkg::MOP_DRRD: dr_row <= rsum[4:0];
      c8ic_pkg::MOP_DRXOR: if ((fr_old & dr_mask) != 64'd0) coll <= 1'b1;
      c8ic_pkg::MOP_RESP: begin
        program_counter <= pc;
        executed_opcode <= (req_l == c8ic_pkg::REQ_EXEC) ? op : 16'd0;
        display_row <= (req_l == c8ic_pkg::REQ_ROW) ? fr_old : 64'd0;
        display_changed <= chg;
        sound_on <= snd_o;
        waiting_key <= wt;
      end
      default: begin
      end
    endcase
  end

  assign st.req = req_l;
  assign st.op = op;
  assign st.clr_last = (clr_addr == c8ic_pkg::ADDR_LAST);
  assign st.draw_break = dr_break;

endmodule

// ----- design/chip8_interpreter_core_unit.sv -----
// CHIP-8 interpreter core. After reset the core sweeps its 4096-byte memory, one byte a
// cycle, to load the font and zero the rest, and takes no request until the sweep is done.
// Each request then yields one result. A memory write, timer tick or display row read
// is done in the start state alone; an instruction also fetches its two opcode bytes,
// reads VX and VY and executes, then writes VF after any ALU operation but a move.
// A register store or load moves one register at a time, a BCD store writes its three
// digits one by one, and a sprite draw reads and XORs one row at a time, then writes VF.
// A new request is taken as soon as the previous result sits in the output register.
// Depends on c8ic_pkg, the channel interfaces, c8ic_ctrl and c8ic_dp.
module chip8_interpreter_core_unit #(
  parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  c8ic_req_if.sink    req,
  c8ic_rsp_if.source  rsp
);

  c8ic_pkg::cmd_t    cmd;
  c8ic_pkg::status_t st;

  // Sequencer.
  c8ic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage and execution.
  c8ic_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .req_type        (req.req_type),
    .address         (req.address),
    .write_byte      (req.write_byte),
    .row_index       (req.row_index),
    .key_state       (req.key_state),
    .random_byte     (req.random_byte),
    .program_counter (rsp.program_counter),
    .executed_opcode (rsp.executed_opcode),
    .display_row     (rsp.display_row),
    .display_changed (rsp.display_changed),
    .sound_on        (rsp.sound_on),
    .waiting_key     (rsp.waiting_key)
  );

endmodule
